>>> rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EMIT
  } state_t;

  // Radix codes carried on the mode field.
  localparam logic [1:0] MODE_HEX = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_BIN = 2'd2;
  localparam logic [1:0] MODE_RSV = 2'd3;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] dig);
    logic [6:0] code;
    if (dig < DIGIT_TEN) begin
      code = ASCII_ZERO + {3'b000, dig};
    end else begin
      code = ASCII_UPPER_A + {3'b000, dig - DIGIT_TEN};
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/itoa_bcd_adj.sv
`default_nettype none

// Double-dabble correction: every BCD digit of five or more gets three added,
// so that the following left shift carries correctly into the next digit.
module itoa_bcd_adj #(
  parameter int WIDTH = 80
) (
  input  wire logic [WIDTH-1:0] bcd_i,
  output logic      [WIDTH-1:0] adj_o
);

  localparam int NDIG = WIDTH / 4;

  for (genvar g = 0; g < NDIG; g++) begin : g_dig
    logic [3:0] dig;
    assign dig = bcd_i[4*g +: 4];
    assign adj_o[4*g +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
  end

endmodule

`default_nettype wire

>>> rtl/integer_to_ascii_radix_top.sv
`default_nettype none

// Sequence: hex walks one digit slot per hex digit, binary one slot per bit, and decimal
// first runs one double-dabble step per value bit and then walks the BCD digit slots.
// Leading zero slots pass without a character, and an output stall holds the walk.
// The block takes no new request until the final character of the last one is registered.
// Reset clears the sequencer and the output valid; no request is in flight after it.
module integer_to_ascii_radix_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_value,
  input  wire logic [1:0]  in_mode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [6:0]  out_character,
  output logic             out_last
);

  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int DEC_W      = DEC_DIGITS * 4;
  localparam int SH_W       = (HEX_W > DEC_W) ? HEX_W : DEC_W;
  localparam int HEX_SH     = SH_W - HEX_W;
  localparam int BIN_SH     = SH_W - VALUE_WIDTH;
  localparam int INS        = SH_W - DEC_W;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  itoa_pkg::state_t state_r, state_nxt;

  logic [SH_W-1:0]        dig_r, dig_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic            ld_in;
  logic            dab_step;
  logic            emit_step;
  logic            cnt_one;
  logic            is_bin;
  logic [3:0]      top_dig;
  logic            show;
  logic [SH_W-1:0] adj;

  itoa_bcd_adj #(
    .WIDTH (SH_W)
  ) u_adj (
    .bcd_i (dig_r),
    .adj_o (adj)
  );

  assign cnt_one = (cnt_r == CNT_W'(1));
  assign is_bin  = (mode_r == itoa_pkg::MODE_BIN);
  assign top_dig = is_bin ? {3'b000, dig_r[SH_W-1]} : dig_r[SH_W-1 -: 4];
  assign show    = started_r | (top_dig != 4'd0) | cnt_one;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == itoa_pkg::MODE_DEC) ? itoa_pkg::ST_DABBLE
                                                      : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_DABBLE: begin
        if (cnt_one) begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (emit_step && cnt_one) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer controls.
  always_comb begin
    in_stall  = 1'b1;
    ld_in     = 1'b0;
    dab_step  = 1'b0;
    emit_step = 1'b0;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ld_in    = in_valid;
      end
      itoa_pkg::ST_DABBLE: begin
        dab_step = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        emit_step = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (ld_in) begin
      mode_nxt    = in_mode;
      started_nxt = 1'b0;
      bin_nxt     = in_value[VALUE_WIDTH-1:0];
      unique case (in_mode) inside
        itoa_pkg::MODE_HEX, itoa_pkg::MODE_RSV: begin
          dig_nxt = SH_W'(in_value[VALUE_WIDTH-1:0]) << HEX_SH;
          cnt_nxt = CNT_W'(HEX_DIGITS);
        end
        itoa_pkg::MODE_DEC: begin
          dig_nxt = '0;
          cnt_nxt = CNT_W'(VALUE_WIDTH);
        end
        itoa_pkg::MODE_BIN: begin
          dig_nxt = SH_W'(in_value[VALUE_WIDTH-1:0]) << BIN_SH;
          cnt_nxt = CNT_W'(VALUE_WIDTH);
        end
        default: begin
          dig_nxt = '0;
        end
      endcase
    end else if (dab_step) begin
      // The BCD digits sit at the top of the shift register; the next binary
      // bit enters the lowest bit of the lowest BCD digit.
      dig_nxt = (adj << 1) | (SH_W'(bin_r[VALUE_WIDTH-1]) << INS);
      bin_nxt = bin_r << 1;
      cnt_nxt = cnt_one ? CNT_W'(DEC_DIGITS) : cnt_r - CNT_W'(1);
    end else if (emit_step) begin
      if (show) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = itoa_pkg::digit_to_ascii(top_dig);
        out_last_nxt  = cnt_one;
        started_nxt   = 1'b1;
      end
      dig_nxt = is_bin ? (dig_r << 1) : (dig_r << 4);
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    mode_r     <= mode_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != itoa_pkg::ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itoa_pkg::ST_EMIT |-> cnt_r != '0)
    else $error("digit count ran out while emitting");

  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itoa_pkg::ST_EMIT && mode_r == itoa_pkg::MODE_DEC |-> top_dig <= 4'd9)
    else $error("double dabble left an invalid BCD digit");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= 7'h30 && out_char_r <= 7'h39) ||
                    (out_char_r >= 7'h41 && out_char_r <= 7'h46))
    else $error("character outside digit range");

endmodule

`default_nettype wire

>>> tb/sv/itoa_digit_checker.sv
module itoa_digit_checker #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_mode,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  out_character,
  input  logic        out_last,
  output int          mismatch_count,
  output int          digits_pending
);

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } ascii_digit_t;

  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);

  ascii_digit_t digit_queue[$];
  int           errors = 0;

  initial begin
    mismatch_count = 0;
    digits_pending = 0;
  end

  // Queues the characters of one request, most significant digit first.
  function automatic void predict_digits(input logic [63:0] raw, input logic [1:0] mode);
    logic [63:0]  num;
    logic [63:0]  base;
    logic [3:0]   dig;
    logic [6:0]   text[$];
    ascii_digit_t item;
    num = raw & VALUE_MASK;
    case (mode)
      itoa_pkg::MODE_DEC: base = 64'd10;
      itoa_pkg::MODE_BIN: base = 64'd2;
      default:            base = 64'd16;
    endcase
    if (num == 64'd0) begin
      text.push_back(itoa_pkg::ASCII_ZERO);
    end else begin
      while (num != 64'd0) begin
        dig = 4'(num % base);
        if (dig < 4'd10) begin
          text.push_front(itoa_pkg::ASCII_ZERO + {3'b000, dig});
        end else begin
          text.push_front(itoa_pkg::ASCII_UPPER_A + {3'b000, dig - 4'd10});
        end
        num = num / base;
      end
    end
    foreach (text[i]) begin
      item.character = text[i];
      item.last      = (i == text.size() - 1);
      digit_queue.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    ascii_digit_t want;
    if (rst_n) begin
      // A result never belongs to a request taken at the same edge, so compare first.
      if (out_valid && !out_stall) begin
        if (digit_queue.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: char %h last %b", out_character, out_last);
          end
        end else begin
          want = digit_queue.pop_front();
          if (want.character !== out_character || want.last !== out_last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       want.character, want.last, out_character, out_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_digits(in_value, in_mode);
      end
    end
    mismatch_count <= errors;
    digits_pending <= digit_queue.size();
  end

endmodule

>>> tb/sv/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 900000;
  localparam int RANDOM_PER_PHASE = 96;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_value;
  logic [1:0]  in_mode;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_character;
  logic        out_last;

  int mismatch_count;
  int digits_pending;
  int sender_idle_pct = 19;
  int receiver_stall_pct = 55;
  int cycle_count = 0;

  always #6 clk = ~clk;

  integer_to_ascii_radix_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  itoa_digit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_character  (out_character),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .digits_pending (digits_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Holds the request until it is taken; valid is only lowered for an idle gap.
  task automatic send_request(input logic [63:0] value, input logic [1:0] mode);
    in_valid <= 1'b1;
    in_value <= value;
    in_mode  <= mode;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= {$urandom, $urandom};
      in_mode  <= 2'($urandom_range(0, 3));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = 64'd0;
      1:       v = {64{1'b1}};
      2:       v = 64'd1 << $urandom_range(0, 63);
      3:       v = 64'($urandom_range(0, 255));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic random_phase(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (RANDOM_PER_PHASE) begin
      send_request(random_value(), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_value  = 64'd0;
    in_mode   = itoa_pkg::MODE_HEX;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and full-width values in every radix, including the reserved code.
    send_request(64'd0, itoa_pkg::MODE_HEX);
    send_request(64'd0, itoa_pkg::MODE_DEC);
    send_request(64'd0, itoa_pkg::MODE_BIN);
    send_request(64'd0, itoa_pkg::MODE_RSV);
    send_request({64{1'b1}}, itoa_pkg::MODE_HEX);
    send_request({64{1'b1}}, itoa_pkg::MODE_DEC);
    send_request({64{1'b1}}, itoa_pkg::MODE_BIN);
    send_request({64{1'b1}}, itoa_pkg::MODE_RSV);
    // Single digits, digit rollovers and every hex letter.
    send_request(64'd1, itoa_pkg::MODE_BIN);
    send_request(64'd9, itoa_pkg::MODE_DEC);
    send_request(64'd10, itoa_pkg::MODE_DEC);
    send_request(64'd15, itoa_pkg::MODE_HEX);
    send_request(64'd16, itoa_pkg::MODE_HEX);
    send_request(64'h0123_4567_89AB_CDEF, itoa_pkg::MODE_HEX);
    send_request(64'hFEDC_BA98_7654_3210, itoa_pkg::MODE_RSV);
    send_request(64'd10000000000000000000, itoa_pkg::MODE_DEC);
    send_request(64'd9999999999999999999, itoa_pkg::MODE_DEC);
    send_request(64'h8000_0000_0000_0000, itoa_pkg::MODE_BIN);
    send_request(64'h8000_0000_0000_0000, itoa_pkg::MODE_DEC);
    send_request(64'h5555_5555_5555_5555, itoa_pkg::MODE_BIN);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, itoa_pkg::MODE_HEX);

    random_phase(19, 55);
    // The sender holds off here until the block has emitted everything.
    in_valid <= 1'b0;
    drain_results();
    random_phase(55, 19);
    random_phase(0, 0);

    in_valid <= 1'b0;
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
